// File: rtl/tcp_connection_tracking_table_top_defines.svh
// assertion macros for the connection tracking table
`ifndef TCP_CONNECTION_TRACKING_TABLE_TOP_DEFINES_SVH
`define TCP_CONNECTION_TRACKING_TABLE_TOP_DEFINES_SVH
// implication checked every clock outside reset
`define CTT_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// next-cycle implication checked every clock outside reset
`define CTT_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// File: rtl/ctt_pkg.sv
// types and constants for the connection tracking table
package ctt_pkg;
  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_ADD = 2'd1;
  localparam logic [1:0] ACT_SET = 2'd2;
  localparam logic [1:0] ACT_FIND = 2'd3;
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NOMATCH = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_SYN_SENT = 3'd1;
  localparam logic [2:0] ST_SYNACK_SENT = 3'd2;
  localparam logic [2:0] ST_ESTABLISHED = 3'd3;
  localparam logic [2:0] ST_FIN1_SENT = 3'd4;
  localparam logic [2:0] ST_FIN1_ACKED = 3'd5;
  localparam logic [2:0] ST_FIN2_SENT = 3'd6;
  // one table row
  typedef struct packed {
    logic [31:0] caddr;
    logic [15:0] cport;
    logic [31:0] saddr;
    logic [15:0] sport;
    logic [2:0] st;
    logic [15:0] pport;
  } entry_t;
  localparam int EntryW = $bits(entry_t);
endpackage

// File: rtl/tcp_connection_tracking_table_top.sv
// top level of the tcp connection tracking table
// one table slot is read per cycle through the single ram port and compared
// by one shared tuple comparator; the next word is taken after done
// no new word is taken while busy; the receiver never stalls
// rst clears valid bits, count and control; table contents stay undefined
`include "tcp_connection_tracking_table_top_defines.svh"
module tcp_connection_tracking_table_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] src_ip,
  input  logic [15:0] src_port,
  input  logic [31:0] dst_ip,
  input  logic [15:0] dst_port,
  input  logic        flag_syn,
  input  logic        flag_fin,
  input  logic        flag_rst,
  input  logic [2:0]  init_state,
  input  logic [15:0] proxy_port,
  output logic        done,
  output logic        verdict,
  output logic [1:0]  status,
  output logic [2:0]  new_state,
  output logic [15:0] client_port,
  output logic [15:0] server_port,
  output logic [6:0]  entry_count
);
  import ctt_pkg::*;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_WAIT = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [1:0] act;
  logic [31:0] sa, da;
  logic [15:0] sp, dp, pp;
  logic syn, fin, rstf;
  logic [AW:0] idx;
  logic [AW-1:0] hit;
  logic found, rev, cmp_vld;
  logic [AW-1:0] cmp_idx;
  logic [MAX_ENTRIES-1:0] valid;
  logic [CW-1:0] count;
  logic [AW-1:0] free_idx;
  logic free_found;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  entry_t wentry, rentry, hentry;
  logic [EntryW-1:0] rword;
  logic [1:0] r_status;
  logic r_verdict;
  logic [2:0] r_nstate;
  logic [15:0] r_cport, r_sport;
  logic fwd_m, rev_m, pp_m, cur_valid;

  ctt_ram #(.WIDTH(EntryW), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wentry), .rdata(rword)
  );
  assign rentry = entry_t'(rword);

  assign cur_valid = valid[cmp_idx];
  assign fwd_m = rentry.caddr == sa && rentry.cport == sp
              && rentry.saddr == da && rentry.sport == dp;
  assign rev_m = rentry.saddr == sa && rentry.sport == sp
              && rentry.caddr == da && rentry.cport == dp;
  assign pp_m = rentry.pport == pp;

  // lowest free slot via priority search on valid bits
  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
      if (!valid[k]) begin
        free_idx = AW'(k);
        free_found = 1'b1;
      end
    end
  end

  // filter state machine
  logic f_verdict, f_remove, f_write;
  logic [2:0] f_state;
  entry_t f_entry;
  always_comb begin
    f_verdict = 1'b0;
    f_remove = 1'b0;
    f_write = 1'b0;
    f_state = hentry.st;
    f_entry = hentry;
    if (rev) begin
      case (hentry.st)
        ST_SYN_SENT: begin
          if (syn && !fin) begin
            f_state = ST_SYNACK_SENT; f_verdict = 1'b1; f_write = 1'b1;
          end else if (rstf) begin
            f_remove = 1'b1; f_verdict = 1'b1;
          end
        end
        ST_ESTABLISHED: begin
          f_verdict = 1'b1;
          if (!syn && fin) begin
            f_state = ST_FIN1_SENT; f_write = 1'b1;
            f_entry.caddr = hentry.saddr;
            f_entry.cport = hentry.sport;
            f_entry.saddr = hentry.caddr;
            f_entry.sport = hentry.cport;
          end
        end
        ST_FIN1_SENT: begin
          if (!syn && !fin) begin
            f_state = ST_FIN1_ACKED; f_verdict = 1'b1; f_write = 1'b1;
          end
        end
        ST_FIN1_ACKED: begin
          if (!syn && fin) begin
            f_state = ST_FIN2_SENT; f_verdict = 1'b1; f_write = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (hentry.st)
        ST_SYNACK_SENT: begin
          if (!syn && !fin) begin
            f_state = ST_ESTABLISHED; f_verdict = 1'b1; f_write = 1'b1;
          end
        end
        ST_ESTABLISHED: begin
          f_verdict = 1'b1;
          if (!syn && fin) begin
            f_state = ST_FIN1_SENT; f_write = 1'b1;
          end
        end
        ST_FIN1_SENT: f_verdict = fin;
        ST_FIN2_SENT: begin
          if (!syn && !fin) begin
            f_remove = 1'b1; f_verdict = 1'b1;
          end
        end
        default: ;
      endcase
    end
    f_entry.st = f_state;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx[AW-1:0];
    wentry = hentry;
    case (state)
      S_IDLE: begin
        ram_addr = free_idx;
        wentry = '{caddr: src_ip, cport: src_port, saddr: dst_ip, sport: dst_port,
                   st: init_state, pport: 16'd0};
        ram_we = start && action == ACT_ADD && free_found;
      end
      S_UPD: begin
        ram_addr = hit;
        if (act == ACT_FILTER) begin
          wentry = f_entry;
          ram_we = found && f_write;
        end else begin
          wentry.pport = pp;
          ram_we = found && act == ACT_SET;
        end
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      count <= '0;
      done <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      cmp_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            act <= action; sa <= src_ip; sp <= src_port; da <= dst_ip;
            dp <= dst_port; syn <= flag_syn; fin <= flag_fin; rstf <= flag_rst;
            pp <= proxy_port;
            found <= 1'b0; rev <= 1'b0; hit <= '0; idx <= '0;
            if (action == ACT_ADD) begin
              if (free_found) begin
                valid[free_idx] <= 1'b1;
                count <= count + 1'b1;
              end
              state <= S_OUT;
              r_status <= free_found ? STAT_DONE : STAT_FULL;
              r_nstate <= free_found ? init_state : ST_NONE;
              r_verdict <= 1'b0; r_cport <= '0; r_sport <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          cmp_vld <= 1'b1;
          cmp_idx <= idx[AW-1:0];
          if (idx == (AW+1)'(MAX_ENTRIES - 1)) state <= S_WAIT;
        end
        S_WAIT: state <= S_UPD;
        S_UPD: begin
          r_verdict <= 1'b0; r_cport <= '0; r_sport <= '0;
          r_status <= found ? STAT_DONE : STAT_NOMATCH;
          r_nstate <= found ? hentry.st : ST_NONE;
          if (found) begin
            case (act)
              ACT_FILTER: begin
                r_verdict <= f_verdict;
                r_nstate <= f_remove ? ST_NONE : f_state;
                if (f_remove) begin
                  valid[hit] <= 1'b0;
                  if (count != '0) count <= count - 1'b1;
                end
              end
              ACT_FIND: begin
                r_cport <= hentry.cport; r_sport <= hentry.sport;
              end
              default: ;
            endcase
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmp_vld && !found && cur_valid) begin
        if (act == ACT_FIND ? pp_m : (fwd_m || rev_m)) begin
          found <= 1'b1;
          rev <= !fwd_m;
          hit <= cmp_idx;
          hentry <= rentry;
        end
      end
    end
  end

  assign verdict = r_verdict;
  assign status = r_status;
  assign new_state = r_nstate;
  assign client_port = r_cport;
  assign server_port = r_sport;
  assign entry_count = 7'(count);

  `CTT_ASSERT_IMP(a_done_pulse, clk, rst, done, !$past(done))
  `CTT_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(MAX_ENTRIES))
  `CTT_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `CTT_ASSERT_IMP(a_count_match, clk, rst, !busy, count == CW'($countones(valid)))
endmodule

// File: rtl/ctt_ram.sv
// generic single-port ram with registered read
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: verif/tcp_connection_tracking_table_top_tb.sv
// testbench for the tcp connection tracking table: directed table then random traffic
`timescale 1ns / 100ps
module tcp_connection_tracking_table_top_tb;
  import ctt_pkg::*;

  localparam int NSLOT = 64;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] sa;
    logic [15:0] sp;
    logic [31:0] da;
    logic [15:0] dp;
    logic        syn;
    logic        fin;
    logic        rst_f;
    logic [2:0]  init;
    logic [15:0] pp;
  } word_t;

  typedef struct packed {
    logic        verdict;
    logic [1:0]  status;
    logic [2:0]  nstate;
    logic [15:0] cport;
    logic [15:0] sport;
    logic [6:0]  count;
  } reply_t;

  typedef struct {
    word_t  w;
    bit     typed;
    reply_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = '0;
  logic [31:0] src_ip = '0;
  logic [15:0] src_port = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] dst_port = '0;
  logic flag_syn = 1'b0;
  logic flag_fin = 1'b0;
  logic flag_rst = 1'b0;
  logic [2:0] init_state = '0;
  logic [15:0] proxy_port = '0;
  logic done;
  logic verdict;
  logic [1:0] status;
  logic [2:0] new_state;
  logic [15:0] client_port;
  logic [15:0] server_port;
  logic [6:0] entry_count;

  tcp_connection_tracking_table_top #(.MAX_ENTRIES(NSLOT)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .src_ip(src_ip), .src_port(src_port), .dst_ip(dst_ip), .dst_port(dst_port),
    .flag_syn(flag_syn), .flag_fin(flag_fin), .flag_rst(flag_rst),
    .init_state(init_state), .proxy_port(proxy_port), .done(done),
    .verdict(verdict), .status(status), .new_state(new_state),
    .client_port(client_port), .server_port(server_port), .entry_count(entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow table
  bit          tbl_valid [NSLOT];
  logic [31:0] tbl_caddr [NSLOT];
  logic [15:0] tbl_cport [NSLOT];
  logic [31:0] tbl_saddr [NSLOT];
  logic [15:0] tbl_sport [NSLOT];
  logic [2:0]  tbl_st [NSLOT];
  logic [15:0] tbl_pport [NSLOT];
  int unsigned live_conns;

  reply_t pending_replies[$];
  int errors = 0;
  int idle_pct = 0;

  function automatic int match_slot(word_t w, output bit from_server);
    from_server = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_valid[i]) continue;
      if (tbl_caddr[i] == w.sa && tbl_cport[i] == w.sp &&
          tbl_saddr[i] == w.da && tbl_sport[i] == w.dp) return i;
      if (tbl_saddr[i] == w.sa && tbl_sport[i] == w.sp &&
          tbl_caddr[i] == w.da && tbl_cport[i] == w.dp) begin
        from_server = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void drop_slot(int i);
    tbl_valid[i] = 1'b0;
    if (live_conns > 0) live_conns--;
  endfunction

  // tcp state machine; returns verdict
  function automatic logic track_packet(int i, bit srv, logic syn, logic fin, logic rf,
                                         output bit gone);
    logic [31:0] ta;
    logic [15:0] tp;
    gone = 1'b0;
    if (srv) begin
      case (tbl_st[i])
        ST_SYN_SENT: begin
          if (syn && !fin) begin
            tbl_st[i] = ST_SYNACK_SENT;
            return 1'b1;
          end
          if (rf) begin
            drop_slot(i);
            gone = 1'b1;
            return 1'b1;
          end
          return 1'b0;
        end
        ST_ESTABLISHED: begin
          if (!syn && fin) begin
            ta = tbl_caddr[i];
            tp = tbl_cport[i];
            tbl_st[i] = ST_FIN1_SENT;
            tbl_caddr[i] = tbl_saddr[i];
            tbl_cport[i] = tbl_sport[i];
            tbl_saddr[i] = ta;
            tbl_sport[i] = tp;
          end
          return 1'b1;
        end
        ST_FIN1_SENT: begin
          if (!syn && !fin) begin
            tbl_st[i] = ST_FIN1_ACKED;
            return 1'b1;
          end
          return 1'b0;
        end
        ST_FIN1_ACKED: begin
          if (!syn && fin) begin
            tbl_st[i] = ST_FIN2_SENT;
            return 1'b1;
          end
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    end
    case (tbl_st[i])
      ST_SYNACK_SENT: begin
        if (!syn && !fin) begin
          tbl_st[i] = ST_ESTABLISHED;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_ESTABLISHED: begin
        if (!syn && fin) tbl_st[i] = ST_FIN1_SENT;
        return 1'b1;
      end
      ST_FIN1_SENT: return fin;
      ST_FIN2_SENT: begin
        if (!syn && !fin) begin
          drop_slot(i);
          gone = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic reply_t predict_reply(word_t w);
    reply_t r;
    bit srv;
    bit gone;
    int i;
    r = '{1'b0, STAT_NOMATCH, ST_NONE, 16'd0, 16'd0, 7'd0};
    case (w.act)
      ACT_FILTER: begin
        i = match_slot(w, srv);
        if (i >= 0) begin
          r.verdict = track_packet(i, srv, w.syn, w.fin, w.rst_f, gone);
          r.status = STAT_DONE;
          r.nstate = gone ? ST_NONE : tbl_st[i];
        end
      end
      ACT_ADD: begin
        r.status = STAT_FULL;
        for (i = 0; i < NSLOT; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_caddr[i] = w.sa;
            tbl_cport[i] = w.sp;
            tbl_saddr[i] = w.da;
            tbl_sport[i] = w.dp;
            tbl_st[i] = w.init;
            tbl_pport[i] = 16'd0;
            live_conns++;
            r.status = STAT_DONE;
            r.nstate = w.init;
            break;
          end
        end
      end
      ACT_SET: begin
        i = match_slot(w, srv);
        if (i >= 0) begin
          tbl_pport[i] = w.pp;
          r.status = STAT_DONE;
          r.nstate = tbl_st[i];
        end
      end
      default: begin
        for (i = 0; i < NSLOT; i++) begin
          if (tbl_valid[i] && tbl_pport[i] == w.pp) begin
            r.cport = tbl_cport[i];
            r.sport = tbl_sport[i];
            r.status = STAT_DONE;
            r.nstate = tbl_st[i];
            break;
          end
        end
      end
    endcase
    r.count = live_conns[6:0];
    return r;
  endfunction

  task automatic send_word(word_t w, bit typed = 1'b0, reply_t given = '{default: '0});
    reply_t r;
    do @(negedge clk); while ($urandom_range(99) < idle_pct);
    action <= w.act;
    src_ip <= w.sa;
    src_port <= w.sp;
    dst_ip <= w.da;
    dst_port <= w.dp;
    flag_syn <= w.syn;
    flag_fin <= w.fin;
    flag_rst <= w.rst_f;
    init_state <= w.init;
    proxy_port <= w.pp;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_reply(w);
    if (typed && r !== given) begin
      $display("%0t: typed row disagrees with predictor", $time);
      errors++;
    end
    pending_replies.push_back(typed ? given : r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word", $time);
        errors++;
      end else begin
        e = pending_replies.pop_front();
        if (verdict !== e.verdict) begin
          $display("%0t: verdict exp %0d got %0d", $time, e.verdict, verdict);
          errors++;
        end
        if (status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status);
          errors++;
        end
        if (new_state !== e.nstate) begin
          $display("%0t: new_state exp %0d got %0d", $time, e.nstate, new_state);
          errors++;
        end
        if (client_port !== e.cport) begin
          $display("%0t: client_port exp %0h got %0h", $time, e.cport, client_port);
          errors++;
        end
        if (server_port !== e.sport) begin
          $display("%0t: server_port exp %0h got %0h", $time, e.sport, server_port);
          errors++;
        end
        if (entry_count !== e.count) begin
          $display("%0t: entry_count exp %0d got %0d", $time, e.count, entry_count);
          errors++;
        end
      end
    end
  end

  // small pools so packets hit live connections
  logic [31:0] ip_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0102};
  logic [15:0] port_pool [4] = '{16'h0, 16'hFFFF, 16'd80, 16'd1234};
  word_t conns[$];

  function automatic word_t rand_word();
    word_t w;
    w.act = 2'($urandom_range(3));
    w.sa = $urandom_range(3) == 0 ? $urandom() : ip_pool[$urandom_range(3)];
    w.da = $urandom_range(3) == 0 ? $urandom() : ip_pool[$urandom_range(3)];
    w.sp = $urandom_range(3) == 0 ? 16'($urandom_range(65535))
                                  : port_pool[$urandom_range(3)];
    w.dp = $urandom_range(3) == 0 ? 16'($urandom_range(65535))
                                  : port_pool[$urandom_range(3)];
    w.syn = 1'($urandom_range(1));
    w.fin = 1'($urandom_range(1));
    w.rst_f = 1'($urandom_range(1));
    w.init = 3'($urandom_range(7));
    w.pp = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(3));
    return w;
  endfunction

  // a packet on a known connection, either direction
  function automatic word_t conn_packet(word_t c, bit srv, logic syn, logic fin);
    word_t w;
    w = c;
    w.act = ACT_FILTER;
    if (srv) begin
      w.sa = c.da; w.sp = c.dp; w.da = c.sa; w.dp = c.sp;
    end
    w.syn = syn;
    w.fin = fin;
    w.rst_f = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic run_session();
    word_t c;
    c = rand_word();
    c.act = ACT_ADD;
    c.sa = $urandom();
    c.sp = 16'($urandom_range(65535));
    c.init = ST_SYN_SENT;
    send_word(c);
    c.act = ACT_SET;
    c.pp = 16'($urandom_range(65535));
    send_word(c);
    if ($urandom_range(4) == 0) begin
      send_word(conn_packet(c, 1'b1, 1'b0, 1'b0));
      return;
    end
    send_word(conn_packet(c, 1'b1, 1'b1, 1'b0));
    send_word(conn_packet(c, 1'b0, 1'b0, 1'b0));
    repeat ($urandom_range(2))
      send_word(conn_packet(c, 1'($urandom_range(1)), 1'b0, 1'b0));
    c.act = ACT_FIND;
    send_word(c);
    if ($urandom_range(1)) begin
      // server closes first: roles swap
      send_word(conn_packet(c, 1'b1, 1'b0, 1'b1));
      c = conn_packet(c, 1'b1, 1'b0, 1'b0);
    end else begin
      send_word(conn_packet(c, 1'b0, 1'b0, 1'b1));
    end
    if ($urandom_range(5) == 0)
      send_word(conn_packet(c, 1'($urandom_range(1)), 1'b1, 1'b1));
    send_word(conn_packet(c, 1'b1, 1'b0, 1'b0));
    send_word(conn_packet(c, 1'b1, 1'b0, 1'b1));
    send_word(conn_packet(c, 1'b0, 1'b0, 1'b0));
  endtask

  row_t dir_rows[$];

  task automatic add_row(logic [1:0] a, logic [31:0] sa, logic [15:0] sp, logic [31:0] da,
                         logic [15:0] dp, logic [2:0] f, logic [2:0] ini, logic [15:0] pp,
                         bit typed = 1'b0, reply_t r = '{default: '0});
    row_t row;
    row.w = '{a, sa, sp, da, dp, f[2], f[1], f[0], ini, pp};
    row.typed = typed;
    row.r = r;
    dir_rows.push_back(row);
  endtask

  initial begin
    word_t w;
    int sent;
    // after reset: nothing matches
    add_row(ACT_FILTER, 32'h0, 16'h0, 32'h0, 16'h0, 3'b000, 3'd0, 16'h0, 1'b1,
            '{1'b0, STAT_NOMATCH, ST_NONE, 16'd0, 16'd0, 7'd0});
    add_row(ACT_FIND, 32'h0, 16'h0, 32'h0, 16'h0, 3'b000, 3'd0, 16'h0, 1'b1,
            '{1'b0, STAT_NOMATCH, ST_NONE, 16'd0, 16'd0, 7'd0});
    add_row(ACT_SET, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 3'b111, 3'd7, 16'hFFFF, 1'b1,
            '{1'b0, STAT_NOMATCH, ST_NONE, 16'd0, 16'd0, 7'd0});
    // extremes and a duplicate add
    add_row(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 3'b111, ST_SYN_SENT, 16'hFFFF,
            1'b1, '{1'b0, STAT_DONE, ST_SYN_SENT, 16'd0, 16'd0, 7'd1});
    add_row(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 3'b000, 3'd7, 16'h0, 1'b1,
            '{1'b0, STAT_DONE, 3'd7, 16'd0, 16'd0, 7'd2});
    add_row(ACT_SET, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 3'b000, 3'd0, 16'hFFFF);
    add_row(ACT_FIND, 32'h0, 16'h0, 32'h0, 16'h0, 3'b000, 3'd0, 16'hFFFF);
    add_row(ACT_FIND, 32'h0, 16'h0, 32'h0, 16'h0, 3'b000, 3'd0, 16'h0);
    // syn-sent: server rst with syn advances, client drops
    add_row(ACT_FILTER, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 3'b100, 3'd0, 16'h0);
    add_row(ACT_FILTER, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 3'b101, 3'd0, 16'h0);
    add_row(ACT_FILTER, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 3'b000, 3'd0, 16'h0);
    add_row(ACT_FILTER, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 3'b110, 3'd0, 16'h0);
    add_row(ACT_FILTER, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 3'b010, 3'd0, 16'h0);
    // rst alone frees a fresh syn-sent entry
    add_row(ACT_ADD, 32'h1, 16'd2, 32'h3, 16'd4, 3'b000, ST_SYN_SENT, 16'h0);
    add_row(ACT_FILTER, 32'h3, 16'd4, 32'h1, 16'd2, 3'b001, 3'd0, 16'h0);
    add_row(ACT_FILTER, 32'h3, 16'd4, 32'h1, 16'd2, 3'b001, 3'd0, 16'h0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[k]) send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].r);

    // fill to full, then one more add
    while (live_conns < NSLOT) begin
      w = rand_word();
      w.act = ACT_ADD;
      send_word(w);
    end
    w.act = ACT_ADD;
    send_word(w, 1'b1, '{1'b0, STAT_FULL, ST_NONE, 16'd0, 16'd0, 7'd64});
    // hold off until the table has answered everything
    while (pending_replies.size() != 0) @(negedge clk);
    // empty the table by closing out via find/filter noise is slow; reset not allowed,
    // so tear slots down through rst on syn-sent entries where possible
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_valid[i] && tbl_st[i] == ST_SYN_SENT) begin
        w = '{ACT_FILTER, tbl_saddr[i], tbl_sport[i], tbl_caddr[i], tbl_cport[i],
              1'b0, 1'b0, 1'b1, 3'd0, 16'd0};
        send_word(w);
      end
    end

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = ph == 0 ? 0 : ph == 1 ? 50 : ph == 2 ? 0 : 6;
      while (sent < (ph + 1) * 470) begin
        if (live_conns > NSLOT - 4) begin
          // free space: drop syn-sent entries via server rst, fin2-sent entries via a client ack
          for (int i = 0; i < NSLOT; i++) begin
            if (tbl_valid[i] && (tbl_st[i] == ST_SYN_SENT || tbl_st[i] == ST_FIN2_SENT)) begin
              if (tbl_st[i] == ST_SYN_SENT)
                w = '{ACT_FILTER, tbl_saddr[i], tbl_sport[i], tbl_caddr[i], tbl_cport[i],
                      1'b0, 1'b0, 1'b1, 3'd0, 16'd0};
              else
                w = '{ACT_FILTER, tbl_caddr[i], tbl_cport[i], tbl_saddr[i], tbl_sport[i],
                      1'b0, 1'b0, 1'b0, 3'd0, 16'd0};
              send_word(w);
              sent++;
            end
          end
        end
        if ($urandom_range(3) == 0) begin
          send_word(rand_word());
          sent++;
        end else begin
          run_session();
          sent += 10;
        end
      end
    end

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (NSLOT + 8) @(posedge clk);
    if (errors == 0)
      $display("tcp_connection_tracking_table_top test passed");
    else
      $display("tcp_connection_tracking_table_top test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tcp_connection_tracking_table_top test failed");
    $finish;
  end
endmodule
